// ===== hdl/stps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table predecessor search: shared package
// Field widths, codes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
package stps_pkg;

    localparam int CFG_W       = 7;   // entry_count register
    localparam int IDX_FIELD_W = 6;   // entry_index / match_index fields
    localparam int POS_FIELD_W = 16;  // entry_position / query_position fields
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register word index taken from paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FIRST = 6'b000010,
        ST_PROBE = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic write;    // store one table entry
        logic capture;  // latch query key and count, read slot zero
        logic first;    // check slot zero, open the search range
        logic probe;    // one binary search step
        logic load;     // latch value at the landing slot
        logic walk;     // step right over an equal neighbor
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;   // saturated count is zero
        logic first_gt;   // slot zero lies above the key
        logic probe_end;  // search loop leaves this cycle
        logic has_next;   // a slot follows the landing slot
        logic walk_more;  // neighbor equal and another slot follows
    } t_dp_stat;

endpackage

// ===== hdl/stps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/stps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search controller
// Sequences write, probe, walk and result steps of the datapath.
// ----------------------------------------------------------------------------
module stps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_query,
    input  stps_pkg::t_dp_stat i_stat,
    output stps_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import stps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_query) begin
                        o_cmd.capture = 1'b1;
                        n_state = i_stat.cnt_zero ? ST_DONE : ST_FIRST;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_FIRST: begin
                o_cmd.first = 1'b1;
                n_state = i_stat.first_gt ? ST_DONE : ST_PROBE;
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.probe_end) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = i_stat.has_next ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_stat.walk_more) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

// ===== hdl/stps_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search datapath
// Position table RAM, search bounds, probe compare and result registers.
// ----------------------------------------------------------------------------
module stps_dp #(
    parameter int TABLE_DEPTH   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stps_pkg::t_dp_cmd                 i_dp_cmd,
    output stps_pkg::t_dp_stat                o_stat,
    input  logic [stps_pkg::CFG_W-1:0]        i_entry_count,
    input  logic [stps_pkg::IDX_FIELD_W-1:0]  i_entry_index,
    input  logic [stps_pkg::POS_FIELD_W-1:0]  i_entry_position,
    input  logic [stps_pkg::POS_FIELD_W-1:0]  i_query_position,
    output logic                              o_found,
    output logic [stps_pkg::IDX_FIELD_W-1:0]  o_match_index
);
    import stps_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_RAW_W = $clog2(TABLE_DEPTH + 2);
    localparam int CW        = (CNT_RAW_W > CFG_W) ? CNT_RAW_W : CFG_W;

    logic [CW-1:0]            cnt_in;
    logic [CW-1:0]            cnt_sat;
    logic [CW-1:0]            r_cnt;
    logic [CW-1:0]            r_lo;
    logic [CW-1:0]            r_hi;
    logic [CW-1:0]            lo_n;
    logic [CW-1:0]            hi_n;
    logic [CW-1:0]            mid_ext;
    logic [CW:0]              sum_n;
    logic [IDX_W-1:0]         r_mid;
    logic [IDX_W-1:0]         mid_n;
    logic [IDX_W-1:0]         mid_e;
    logic [IDX_W-1:0]         mid0;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         wr_addr;
    logic [POSITION_BITS-1:0] r_key;
    logic [POSITION_BITS-1:0] r_val;
    logic [POSITION_BITS-1:0] rdata;
    logic [POSITION_BITS-1:0] wdata;
    logic                     r_found;
    logic                     v_lt;
    logic                     v_gt;
    logic                     v_eq;
    logic                     wr_ok;
    logic                     we;
    logic                     probe_end;

    // table write: drop slots beyond the depth
    assign wr_ok   = (32'(i_entry_index) < 32'(TABLE_DEPTH));
    assign we      = i_dp_cmd.write && wr_ok;
    assign wr_addr = IDX_W'(i_entry_index);
    assign wdata   = POSITION_BITS'(i_entry_position);

    stps_ram #(
        .WIDTH (POSITION_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign cnt_in  = CW'(i_entry_count);
    assign cnt_sat = (cnt_in > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_in;

    assign v_lt    = (rdata < r_key);
    assign v_gt    = (rdata > r_key);
    assign v_eq    = (rdata == r_key);
    assign mid_ext = CW'(r_mid);

    // next search range, upper bound kept exclusive
    always_comb begin
        lo_n = r_lo;
        hi_n = r_hi;
        if (v_lt) begin
            lo_n = mid_ext + CW'(1);
        end else if (v_gt) begin
            hi_n = mid_ext;
        end
    end

    assign sum_n     = {1'b0, lo_n} + {1'b0, hi_n} - (CW + 1)'(1);
    assign mid_n     = IDX_W'(sum_n[CW:1]);
    assign probe_end = v_eq || !(lo_n < hi_n);
    // landing slot when the search ends: the matching slot, else one below the lower bound
    assign mid_e     = v_eq ? r_mid :
                       ((lo_n == '0) ? '0 : IDX_W'(lo_n - CW'(1)));
    assign mid0      = IDX_W'((r_cnt - CW'(1)) >> 1);

    always_comb begin
        rd_addr = r_mid;
        if (i_dp_cmd.capture) begin
            rd_addr = '0;
        end else if (i_dp_cmd.first) begin
            rd_addr = mid0;
        end else if (i_dp_cmd.probe) begin
            rd_addr = probe_end ? mid_e : mid_n;
        end else if (i_dp_cmd.load) begin
            rd_addr = IDX_W'(mid_ext + CW'(1));
        end else if (i_dp_cmd.walk) begin
            rd_addr = IDX_W'(mid_ext + CW'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_key   <= POSITION_BITS'(i_query_position);
            r_cnt   <= cnt_sat;
            r_found <= 1'b0;
            r_mid   <= '0;
        end
        if (i_dp_cmd.first) begin
            r_lo <= '0;
            r_hi <= r_cnt;
            if (!v_gt) begin
                r_found <= 1'b1;
                r_mid   <= mid0;
            end
        end
        if (i_dp_cmd.probe) begin
            r_lo  <= lo_n;
            r_hi  <= hi_n;
            r_mid <= probe_end ? mid_e : mid_n;
        end
        if (i_dp_cmd.load) begin
            r_val <= rdata;
        end
        if (i_dp_cmd.walk && (rdata == r_val)) begin
            r_mid <= r_mid + IDX_W'(1);
        end
    end

    assign o_stat.cnt_zero  = (cnt_sat == '0);
    assign o_stat.first_gt  = v_gt;
    assign o_stat.probe_end = probe_end;
    assign o_stat.has_next  = ((mid_ext + CW'(1)) < r_cnt);
    assign o_stat.walk_more = (rdata == r_val) && ((mid_ext + CW'(2)) < r_cnt);

    assign o_found       = r_found;
    assign o_match_index = r_found ? IDX_FIELD_W'(r_mid) : '0;

    a_probe_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.probe |-> (r_lo < r_hi))
        else $error("probe with empty search range");

    a_walk_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.walk |-> ((mid_ext + CW'(1)) < r_cnt))
        else $error("walk past last valid entry");

    a_first_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.first |-> (r_cnt != '0))
        else $error("search started on empty table");

    a_probe_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.probe && !probe_end) |=> i_dp_cmd.probe)
        else $error("search left before range closed");

endmodule

// ===== hdl/sorted_table_predecessor_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table predecessor search: top level
// Table of sorted positions with a binary search for the last entry that is
// not above a query position.
//
// Usage: load entry_count over APB (byte address 0). A transaction is taken
// when start is high and busy is low. cmd 0 writes entry_position into slot
// entry_index in the accept cycle and gives no result; busy stays low, so the
// next write may follow at once. cmd 1 runs a query: busy rises, and the
// answer is valid on o_found / o_match_index while o_done is high for one
// cycle and held until the next query; busy falls in the next cycle.
// A query checks slot zero, then runs binary search probes (at most
// ceil(log2(count+1)), 7 for 64 entries), loads the landing slot and takes
// walk steps over equal right neighbors (none when the landing slot is
// the last valid one, else the equal run plus one, or the run alone when
// it reaches the last valid entry). An empty table skips the search and
// answers straight from the accept state, and a query below the first entry
// answers right after the check of slot zero. Each probe costs one access
// to the single read port of the table RAM; no new transaction is taken
// while a query is busy. The result cannot be stalled.
// Reset clears the controller and entry_count; table contents are kept
// and must be written before they are searched.
// ----------------------------------------------------------------------------
module sorted_table_predecessor_search_top #(
    parameter int TABLE_DEPTH   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [stps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [stps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [stps_pkg::IDX_FIELD_W-1:0]  i_entry_index,
    input  logic [stps_pkg::POS_FIELD_W-1:0]  i_entry_position,
    input  logic [stps_pkg::POS_FIELD_W-1:0]  i_query_position,
    output logic                              o_done,
    output logic                              o_found,
    output logic [stps_pkg::IDX_FIELD_W-1:0]  o_match_index
);
    import stps_pkg::*;

    logic [CFG_W-1:0] r_entry_count;
    logic             cfg_wr;
    logic             reg_sel;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_ENTRY_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_wr) begin
            r_entry_count <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(r_entry_count) : '0;

    stps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_query (i_cmd == CMD_QUERY),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    stps_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .o_stat           (dp_stat),
        .i_entry_count    (r_entry_count),
        .i_entry_index    (i_entry_index),
        .i_entry_position (i_entry_position),
        .i_query_position (i_query_position),
        .o_found          (o_found),
        .o_match_index    (o_match_index)
    );

endmodule

// ===== tb/sv/sorted_table_predecessor_search_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table predecessor search: self-checking testbench
// Loads position tables through the write command, sets entry_count over APB
// and runs predecessor queries. Every answer is checked against a local
// binary search over a shadow copy of the table. Directed cases cover empty
// tables, extremes, equal runs, counts above the depth and unsorted tables;
// random sets of sorted tables with random queries follow.
// ----------------------------------------------------------------------------
module sorted_table_predecessor_search_top_test;
    import stps_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int RUN_LIMIT    = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [APB_ADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    typedef struct packed {
        logic                   found;
        logic [IDX_FIELD_W-1:0] match_index;
    } t_search_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   start;
    logic                   busy;
    logic                   i_cmd;
    logic [IDX_FIELD_W-1:0] i_entry_index;
    logic [POS_FIELD_W-1:0] i_entry_position;
    logic [POS_FIELD_W-1:0] i_query_position;
    logic                   o_done;
    logic                   o_found;
    logic [IDX_FIELD_W-1:0] o_match_index;

    // shadow state of the block
    logic [POS_FIELD_W-1:0] slot_positions [TABLE_DEPTH];
    logic [CFG_W-1:0]       entry_count_reg;

    t_search_result pending_answers [$];
    t_search_result want;
    int             mismatches  = 0;
    int             items_sent  = 0;
    int             idle_pct    = 0;
    int             cycle_count = 0;

    sorted_table_predecessor_search_top #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .POSITION_BITS(POS_FIELD_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .i_entry_position(i_entry_position),
        .i_query_position(i_query_position),
        .o_done          (o_done),
        .o_found         (o_found),
        .o_match_index   (o_match_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Binary search as the block runs it, including the walk over equal
    // neighbors and the count saturation at the table depth.
    function automatic t_search_result locate_predecessor(input logic [POS_FIELD_W-1:0] key);
        t_search_result r;
        int             n;
        int             lo;
        int             hi;
        int             mid;
        r = '0;
        n = (entry_count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_reg);
        if (n == 0 || slot_positions[0] > key) return r;
        lo  = 0;
        hi  = n - 1;
        mid = (lo + hi) / 2;
        while (lo <= hi) begin
            if (slot_positions[mid] < key) lo = mid + 1;
            else if (slot_positions[mid] > key) hi = mid - 1;
            else break;
            mid = (lo + hi) / 2;
        end
        if (mid < 0) mid = 0;
        while (mid < n - 1 && slot_positions[mid] == slot_positions[mid + 1]) mid++;
        r.found       = 1'b1;
        r.match_index = mid[IDX_FIELD_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: answer with no query pending: found=%0d index=%0d",
                         $time, o_found, o_match_index);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (o_found !== want.found || o_match_index !== want.match_index) begin
                    $display({"%0t: answer mismatch: expected found=%0d index=%0d, ",
                              "got found=%0d index=%0d"},
                             $time, want.found, want.match_index, o_found, o_match_index);
                    mismatches++;
                end
            end
        end
    end

    task automatic issue_command(input logic cmd, input logic [IDX_FIELD_W-1:0] idx,
                                 input logic [POS_FIELD_W-1:0] epos,
                                 input logic [POS_FIELD_W-1:0] qpos);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_entry_index    <= idx;
        i_entry_position <= epos;
        i_query_position <= qpos;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (cmd == CMD_WRITE) slot_positions[idx] = epos;
        else pending_answers.push_back(locate_predecessor(qpos));
    endtask

    // unused fields carry random values: the block must ignore them
    task automatic write_slot(input int idx, input int pos);
        issue_command(CMD_WRITE, idx[IDX_FIELD_W-1:0], pos[POS_FIELD_W-1:0],
                      POS_FIELD_W'($urandom));
    endtask

    task automatic query_position(input int key);
        issue_command(CMD_QUERY, IDX_FIELD_W'($urandom), POS_FIELD_W'($urandom),
                      key[POS_FIELD_W-1:0]);
    endtask

    // Drop start and let the last query finish before touching the register.
    task automatic wait_for_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write followed by a back-to-back read of the same register.
    task automatic write_entry_count(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRY_COUNT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        entry_count_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(value)) begin
            $display("%0t: entry_count read mismatch: expected %0d, got %0d",
                     $time, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sorted run in slots 0..n-1: spread out, dense with repeats, or wide.
    task automatic load_sorted_run(input int n, input int style);
        int v;
        int i;
        v = $urandom_range(0, 3000);
        for (i = 0; i < n; i++) begin
            write_slot(i, v);
            case (style)
                0: begin
                    v += $urandom_range(0, 2000);
                end
                1: begin
                    v += $urandom_range(0, 1);
                end
                default: begin
                    v += $urandom_range(0, 131070 / n);
                end
            endcase
            if (v > 65535) v = 65535;
        end
    endtask

    function automatic int pick_key(input int n_live);
        int k;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) k = 0;
        else if (r == 1) k = 65535;
        else if (r <= 6 && n_live > 0) begin
            k = slot_positions[$urandom_range(0, n_live - 1)];
            if (r == 5) k = (k - 1) & 16'hFFFF;
            else if (r == 6) k = (k + 1) & 16'hFFFF;
        end else k = $urandom_range(0, 65535);
        return k;
    endfunction

    // Fixed table: steps of 1000 from 100, an equal run in slots 20..22 and
    // the top value repeated in the last two slots.
    task automatic test_table_load();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (i >= 62) write_slot(i, 65535);
            else if (i >= 20 && i <= 22) write_slot(i, 20100);
            else write_slot(i, 100 + i * 1000);
        end
    endtask

    task automatic test_empty_table();
        wait_for_answers();
        write_entry_count(7'd0);
        query_position(0);
        query_position(65535);
        wait_for_answers();
        write_entry_count(7'd1);
        query_position(99);
        query_position(100);
        query_position(65535);
    endtask

    task automatic test_full_table();
        wait_for_answers();
        write_entry_count(7'd64);
        query_position(0);
        query_position(99);
        query_position(100);
        query_position(20099);
        query_position(20100);
        query_position(30100);
        query_position(61100);
        query_position(65534);
        query_position(65535);
    endtask

    task automatic test_count_above_depth();
        wait_for_answers();
        write_entry_count(7'd127);
        query_position(65535);
        query_position(50000);
        wait_for_answers();
        write_entry_count(7'd65);
        query_position(20100);
    endtask

    task automatic test_unsorted_table();
        wait_for_answers();
        write_entry_count(7'd64);
        write_slot(31, 0);
        write_slot(32, 65535);
        query_position(31100);
        query_position(40100);
        query_position(65535);
        query_position(0);
    endtask

    // Random sorted tables with a random count; a few stray writes break
    // the order now and then.
    task automatic test_sorted_sets(input int quota, input int idle);
        int               base;
        int               n_live;
        logic [CFG_W-1:0] cnt;
        idle_pct = idle;
        base     = items_sent;
        while (items_sent - base < quota) begin
            case ($urandom_range(0, 9))
                0: begin
                    cnt = 7'd0;
                end
                1: begin
                    cnt = 7'd64;
                end
                2: begin
                    cnt = CFG_W'($urandom_range(65, 127));
                end
                3, 4, 5, 6: begin
                    cnt = CFG_W'($urandom_range(1, 8));
                end
                default: begin
                    cnt = CFG_W'($urandom_range(9, 63));
                end
            endcase
            n_live = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
            wait_for_answers();
            write_entry_count(cnt);
            load_sorted_run(n_live, $urandom_range(0, 2));
            repeat ($urandom_range(6, 20)) begin
                if ($urandom_range(99) < 15)
                    write_slot($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 65535));
                else
                    query_position(pick_key(n_live));
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        start            <= 1'b0;
        i_cmd            <= CMD_WRITE;
        i_entry_index    <= '0;
        i_entry_position <= '0;
        i_query_position <= '0;
        entry_count_reg  = '0;
        foreach (slot_positions[i]) slot_positions[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_empty_table();
        test_full_table();
        test_count_above_depth();
        test_unsorted_table();
        test_sorted_sets(90, 16);
        test_sorted_sets(90, 77);
        test_sorted_sets(90, 0);
        wait_for_answers();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
